/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the block statistics design.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition in the same cycle as its trigger.
`define ASSERT_SAME_CYCLE(lbl, clk_i, rstn_i, ante, cons) \
    lbl: assert property (@(posedge clk_i) disable iff (!(rstn_i)) (ante) |-> (cons)) \
        else $error("same-cycle assertion failed");

// Check a condition in the cycle after its trigger.
`define ASSERT_NEXT_CYCLE(lbl, clk_i, rstn_i, ante, cons) \
    lbl: assert property (@(posedge clk_i) disable iff (!(rstn_i)) (ante) |=> (cons)) \
        else $error("next-cycle assertion failed");

`endif

/* design/bmsd_pkg.sv */
// ----------------------------------------------------------------------------
// bmsd_pkg
// Widths, command and status types for the block mean and deviation design.
// ----------------------------------------------------------------------------
`default_nettype none

package bmsd_pkg;

    localparam int WINDOW_LOG2 = 11;
    localparam int SAMPLE_BITS = 24;
    localparam int WORD_W      = 24;
    localparam int OUT_W       = 35;

    localparam int CNT_W   = WINDOW_LOG2;
    localparam int SUM_W   = SAMPLE_BITS + WINDOW_LOG2;
    localparam int SQR_W   = 2 * SAMPLE_BITS - 1;
    localparam int SQ_W    = SQR_W + WINDOW_LOG2;
    localparam int RAD_W   = SQ_W + WINDOW_LOG2;
    localparam int ROOT_W  = (RAD_W + 1) / 2;
    localparam int RAD2_W  = 2 * ROOT_W;
    localparam int REM_W   = ROOT_W + 2;
    localparam int STEP_W  = $clog2((SUM_W > ROOT_W) ? SUM_W : ROOT_W);

    typedef struct packed {
        logic load;
        logic mul_step;
        logic sub;
        logic sqrt_step;
    } dp_cmd_t;

    typedef struct packed {
        logic full;
    } acc_status_t;

endpackage

`default_nettype wire

/* design/bmsd_accum.sv */
// ----------------------------------------------------------------------------
// bmsd_accum
// Input stage: square each sample, accumulate sum and sum of squares, and
// hand each finished block to a one-entry holding slot.
// ----------------------------------------------------------------------------
`default_nettype none

module bmsd_accum
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic [7:0]                            sample_high,
    input  wire logic [7:0]                            sample_mid,
    input  wire logic [7:0]                            sample_low,
    input  wire logic                                  snap_take,
    output bmsd_pkg::acc_status_t                      status,
    output logic signed [bmsd_pkg::SUM_W-1:0]          snap_sum,
    output logic        [bmsd_pkg::SQ_W-1:0]           snap_sq
);

    localparam int SB = bmsd_pkg::SAMPLE_BITS;

    logic [bmsd_pkg::CNT_W-1:0]          count_reg;
    logic                                a_valid_reg;
    logic                                a_last_reg;
    logic signed [SB-1:0]                a_smp_reg;
    logic                                b_valid_reg;
    logic                                b_last_reg;
    logic signed [SB-1:0]                b_smp_reg;
    logic [bmsd_pkg::SQR_W-1:0]          b_sq_reg;
    logic signed [bmsd_pkg::SUM_W-1:0]   sum_reg;
    logic [bmsd_pkg::SQ_W-1:0]           sq_reg;
    logic signed [bmsd_pkg::SUM_W-1:0]   snap_sum_reg;
    logic [bmsd_pkg::SQ_W-1:0]           snap_sq_reg;
    logic                                full_reg;

    logic [bmsd_pkg::WORD_W-1:0]         word;
    logic                                accept;
    logic                                in_last;
    logic signed [2*SB-1:0]              a_prod;
    logic signed [bmsd_pkg::SUM_W-1:0]   sum_next;
    logic [bmsd_pkg::SQ_W-1:0]           sq_next;

    assign word     = {sample_high, sample_mid, sample_low};
    assign in_last  = &count_reg;
    assign in_ready = !(in_last && (full_reg || (a_valid_reg && a_last_reg)
                                             || (b_valid_reg && b_last_reg)));
    assign accept   = in_valid && in_ready;

    assign a_prod   = a_smp_reg * a_smp_reg;
    assign sum_next = sum_reg + bmsd_pkg::SUM_W'(b_smp_reg);
    assign sq_next  = sq_reg + bmsd_pkg::SQ_W'(b_sq_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            a_valid_reg <= 1'b0;
            a_last_reg  <= 1'b0;
            b_valid_reg <= 1'b0;
            b_last_reg  <= 1'b0;
            sum_reg     <= '0;
            sq_reg      <= '0;
            full_reg    <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg <= count_reg + 1'b1;
            end
            a_valid_reg <= accept;
            a_last_reg  <= in_last;
            b_valid_reg <= a_valid_reg;
            b_last_reg  <= a_last_reg;
            if (b_valid_reg)
            begin
                if (b_last_reg)
                begin
                    sum_reg <= '0;
                    sq_reg  <= '0;
                end
                else
                begin
                    sum_reg <= sum_next;
                    sq_reg  <= sq_next;
                end
            end
            if (b_valid_reg && b_last_reg)
            begin
                full_reg <= 1'b1;
            end
            else if (snap_take)
            begin
                full_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        a_smp_reg <= signed'(word[SB-1:0]);
        b_smp_reg <= a_smp_reg;
        b_sq_reg  <= a_prod[bmsd_pkg::SQR_W-1:0];
        if (b_valid_reg && b_last_reg)
        begin
            snap_sum_reg <= sum_next;
            snap_sq_reg  <= sq_next;
        end
    end

    assign status.full = full_reg;
    assign snap_sum    = snap_sum_reg;
    assign snap_sq     = snap_sq_reg;

endmodule

`default_nettype wire

/* design/bmsd_ctrl.sv */
// ----------------------------------------------------------------------------
// bmsd_ctrl
// Sequencer for the end-of-block work: load, square the sum, form the
// radicand, take the square root, then present the result.
// ----------------------------------------------------------------------------
`default_nettype none

module bmsd_ctrl
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire bmsd_pkg::acc_status_t   status,
    output bmsd_pkg::dp_cmd_t            cmd,
    output logic                         out_valid,
    input  wire logic                    out_ready
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_SUB  = 3'd2;
    localparam logic [2:0] ST_SQRT = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    localparam logic [bmsd_pkg::STEP_W-1:0] MUL_LAST  = bmsd_pkg::STEP_W'(bmsd_pkg::SUM_W - 1);
    localparam logic [bmsd_pkg::STEP_W-1:0] SQRT_LAST = bmsd_pkg::STEP_W'(bmsd_pkg::ROOT_W - 1);

    logic [2:0]                    state_reg;
    logic [2:0]                    state_next;
    logic [bmsd_pkg::STEP_W-1:0]   step_reg;
    logic [bmsd_pkg::STEP_W-1:0]   step_next;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        out_valid  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (status.full)
                begin
                    cmd.load   = 1'b1;
                    step_next  = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == MUL_LAST)
                begin
                    state_next = ST_SUB;
                end
            end
            ST_SUB:
            begin
                cmd.sub    = 1'b1;
                step_next  = '0;
                state_next = ST_SQRT;
            end
            ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                step_next     = step_reg + 1'b1;
                if (step_reg == SQRT_LAST)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

`default_nettype wire

/* design/bmsd_dp.sv */
// ----------------------------------------------------------------------------
// bmsd_dp
// End-of-block datapath: shift-add square of the block sum, radicand
// subtract, and a one-bit-per-step integer square root.
// ----------------------------------------------------------------------------
`default_nettype none

module bmsd_dp
(
    input  wire logic                                  clk,
    input  wire bmsd_pkg::dp_cmd_t                     cmd,
    input  wire logic signed [bmsd_pkg::SUM_W-1:0]     snap_sum,
    input  wire logic        [bmsd_pkg::SQ_W-1:0]      snap_sq,
    output logic signed      [bmsd_pkg::OUT_W-1:0]     mean_times_n,
    output logic             [bmsd_pkg::OUT_W-1:0]     deviation_times_n
);

    localparam int W = bmsd_pkg::SUM_W;

    logic signed [W-1:0]                 sum_reg;
    logic [bmsd_pkg::SQ_W-1:0]           sq_reg;
    logic [W-1:0]                        mcand_reg;
    logic [2*W-1:0]                      p_reg;
    logic [bmsd_pkg::RAD2_W-1:0]         rad_reg;
    logic [bmsd_pkg::REM_W-1:0]          rem_reg;
    logic [bmsd_pkg::ROOT_W-1:0]         root_reg;

    logic [W-1:0]                        mag;
    logic [W:0]                          upper;
    logic [bmsd_pkg::RAD_W-1:0]          scaled;
    logic [bmsd_pkg::RAD_W-1:0]          diff;
    logic [bmsd_pkg::REM_W:0]            rem_sh;
    logic [bmsd_pkg::REM_W:0]            trial;
    logic                                fits;
    logic [bmsd_pkg::REM_W:0]            rem_sub;

    assign mag    = snap_sum[W-1] ? W'(-snap_sum) : W'(snap_sum);
    assign upper  = {1'b0, p_reg[2*W-1:W]} + (p_reg[0] ? {1'b0, mcand_reg} : '0);
    assign scaled = {sq_reg, {bmsd_pkg::WINDOW_LOG2{1'b0}}};
    assign diff   = scaled - p_reg[bmsd_pkg::RAD_W-1:0];
    assign rem_sh = {rem_reg[bmsd_pkg::REM_W-2:0], rad_reg[bmsd_pkg::RAD2_W-1 -: 2]};
    assign trial  = (bmsd_pkg::REM_W+1)'({root_reg, 2'b01});
    assign fits   = rem_sh >= trial;
    assign rem_sub = rem_sh - trial;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sum_reg   <= snap_sum;
            sq_reg    <= snap_sq;
            mcand_reg <= mag;
            p_reg     <= {{W{1'b0}}, mag};
        end
        if (cmd.mul_step)
        begin
            p_reg <= {upper, p_reg[W-1:1]};
        end
        if (cmd.sub)
        begin
            rad_reg  <= bmsd_pkg::RAD2_W'(diff);
            rem_reg  <= '0;
            root_reg <= '0;
        end
        if (cmd.sqrt_step)
        begin
            rad_reg <= {rad_reg[bmsd_pkg::RAD2_W-3:0], 2'b00};
            if (fits)
            begin
                rem_reg  <= rem_sub[bmsd_pkg::REM_W-1:0];
                root_reg <= {root_reg[bmsd_pkg::ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh[bmsd_pkg::REM_W-1:0];
                root_reg <= {root_reg[bmsd_pkg::ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign mean_times_n      = bmsd_pkg::OUT_W'(sum_reg);
    assign deviation_times_n = bmsd_pkg::OUT_W'(root_reg);

endmodule

`default_nettype wire

/* design/block_mean_and_std_deviation.sv */
// ----------------------------------------------------------------------------
// block_mean_and_std_deviation: block sum and scaled standard deviation.
// Throughput one item per cycle; the last item of a block waits while the
// one-block snapshot slot is still occupied by an earlier block or while an
// earlier last item is in the square and accumulate stages. Each result is
// formed by the 35-step shift-add square and 35-step bit-serial square root.
// Reset (rst_n low, asynchronous) clears count, accumulators and sequencer.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module block_mean_and_std_deviation
(
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_valid,
    output logic                                        in_ready,
    input  wire logic [7:0]                             sample_high,
    input  wire logic [7:0]                             sample_mid,
    input  wire logic [7:0]                             sample_low,
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output logic signed [bmsd_pkg::OUT_W-1:0]           mean_times_n,
    output logic        [bmsd_pkg::OUT_W-1:0]           deviation_times_n
);

    bmsd_pkg::acc_status_t                 status;
    bmsd_pkg::dp_cmd_t                     cmd;
    logic signed [bmsd_pkg::SUM_W-1:0]     snap_sum;
    logic        [bmsd_pkg::SQ_W-1:0]      snap_sq;

    bmsd_accum u_accum
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .sample_high (sample_high),
        .sample_mid  (sample_mid),
        .sample_low  (sample_low),
        .snap_take   (cmd.load),
        .status      (status),
        .snap_sum    (snap_sum),
        .snap_sq     (snap_sq)
    );

    bmsd_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .status    (status),
        .cmd       (cmd),
        .out_valid (out_valid),
        .out_ready (out_ready)
    );

    bmsd_dp u_dp
    (
        .clk               (clk),
        .cmd               (cmd),
        .snap_sum          (snap_sum),
        .snap_sq           (snap_sq),
        .mean_times_n      (mean_times_n),
        .deviation_times_n (deviation_times_n)
    );

    `ASSERT_SAME_CYCLE(a_load_needs_block, clk, rst_n, cmd.load, status.full)
    `ASSERT_SAME_CYCLE(a_cmd_onehot, clk, rst_n, 1'b1, $onehot0(cmd))
    `ASSERT_SAME_CYCLE(a_out_quiet, clk, rst_n, out_valid, cmd == '0)
    `ASSERT_NEXT_CYCLE(a_sub_then_root, clk, rst_n, cmd.sub, cmd.sqrt_step)

endmodule

`default_nettype wire
